// File: hdl/pasc_pkg.sv
// shared types and constants for the pedal adc smoother
`timescale 1ns / 1ps

package pasc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_MIDI_CHANNEL    = 2'd1;
    localparam logic [1:0] CFG_CONTROLLER_BASE = 2'd2;

    // operation codes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_PRIME  = 1'b1;

    // reset values of the configuration registers
    localparam logic [7:0] RST_CHANNEL_ENABLE  = 8'd0;
    localparam logic [3:0] RST_MIDI_CHANNEL    = 4'd0;
    localparam logic [6:0] RST_CONTROLLER_BASE = 7'd20;

    // quantizer: divide by 32, report threshold half a step, snap beyond three steps
    localparam int unsigned SCALE_SHIFT = 5;
    localparam int unsigned HALF_SCALE  = 16;
    localparam int unsigned SNAP_LIMIT  = 96;
    localparam logic [6:0]  LEVEL_MAX   = 7'd127;

    // write strobes from the update logic to the channel store and the output register
    typedef struct packed {
        logic filt_we;
        logic rep_we;
        logic emit;
    } t_store_ctl;

endpackage

// File: hdl/pasc_state.sv
// per-channel filter and reported-value store
`timescale 1ns / 1ps

module pasc_state #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [2:0]                 i_channel,
    input  pasc_pkg::t_store_ctl       i_ctl,
    input  logic [SAMPLE_BITS-1:0]     i_filt_wdata,
    input  logic [SAMPLE_BITS-1:0]     i_rep_wdata,
    output logic [SAMPLE_BITS-1:0]     o_filt,
    output logic [SAMPLE_BITS-1:0]     o_rep
);

    logic [SAMPLE_BITS-1:0] r_filt [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] r_rep  [NUM_CHANNELS];

    // read by compare so entries beyond the channel field never alias
    always_comb begin
        o_filt = '0;
        o_rep  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (int'(i_channel) == i) begin
                o_filt = r_filt[i];
                o_rep  = r_rep[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_filt[i] <= '0;
                r_rep[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (int'(i_channel) == i) begin
                    if (i_ctl.filt_we) begin
                        r_filt[i] <= i_filt_wdata;
                    end
                    if (i_ctl.rep_we) begin
                        r_rep[i] <= i_rep_wdata;
                    end
                end
            end
        end
    end

endmodule

// File: hdl/pasc_step.sv
// filter update, quantizer and report decision for one sample
`timescale 1ns / 1ps

module pasc_step #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_active,
    input  logic                   i_op,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [2:0]             i_slot,
    input  logic [6:0]             i_base,
    input  logic [SAMPLE_BITS-1:0] i_old,
    input  logic [SAMPLE_BITS-1:0] i_rep,
    output pasc_pkg::t_store_ctl   o_ctl,
    output logic [SAMPLE_BITS-1:0] o_filt_wdata,
    output logic [6:0]             o_level,
    output logic [6:0]             o_controller_number
);

    function automatic logic [6:0] quantize(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] q;
        q = v >> pasc_pkg::SCALE_SHIFT;
        if (q > SAMPLE_BITS'(pasc_pkg::LEVEL_MAX)) begin
            q = SAMPLE_BITS'(pasc_pkg::LEVEL_MAX);
        end
        return q[6:0];
    endfunction

    logic [SAMPLE_BITS+1:0] w_sum;
    logic [SAMPLE_BITS-1:0] w_now;
    logic [SAMPLE_BITS-1:0] w_err;
    logic [6:0]             w_prev_q;
    logic [6:0]             w_new_q;
    logic                   w_report;
    logic                   w_snap;
    logic [7:0]             w_cc_sum;

    // (3*old + sample) / 4
    assign w_sum = {1'b0, i_old, 1'b0} + {2'b00, i_old} + {2'b00, i_sample};
    assign w_now = w_sum[SAMPLE_BITS+1:2];

    assign w_prev_q = quantize(i_old);
    assign w_new_q  = quantize(w_now);
    assign w_err    = (i_rep > w_now) ? (i_rep - w_now) : (w_now - i_rep);

    assign w_report = (w_new_q != w_prev_q)
                   && ((w_err >= SAMPLE_BITS'(pasc_pkg::HALF_SCALE))
                       || (w_new_q == 7'd0)
                       || (w_new_q == pasc_pkg::LEVEL_MAX));
    assign w_snap   = w_err > SAMPLE_BITS'(pasc_pkg::SNAP_LIMIT);

    always_comb begin
        o_ctl        = '0;
        o_filt_wdata = w_now;
        if (i_active) begin
            o_ctl.filt_we = 1'b1;
            if (i_op == pasc_pkg::OP_PRIME) begin
                o_filt_wdata = i_sample;
            end else if (w_report) begin
                o_ctl.rep_we = 1'b1;
                o_ctl.emit   = 1'b1;
                if (w_snap) begin
                    o_filt_wdata = i_sample;
                end
            end
        end
    end

    assign o_level = w_new_q;

    // controller number saturates at the top of the range
    assign w_cc_sum = {1'b0, i_base} + {5'b00000, i_slot};
    assign o_controller_number = (w_cc_sum > {1'b0, pasc_pkg::LEVEL_MAX})
                               ? pasc_pkg::LEVEL_MAX : w_cc_sum[6:0];

endmodule

// File: hdl/pedal_adc_smoother_cc_core.sv
// top level: input register, per-channel smoother and control-change output register
`timescale 1ns / 1ps
// a result is written to the output register as its input leaves the input register, and
//   the input stays held while the output register is full and stalled
// throughput: one input transaction per cycle while the output is not stalled; the
//   per-channel state is read, updated and written back between input and output registers
// reset (synchronous, active low): filter and reported values cleared, channel mask 0,
//   midi channel 0, controller base 20, both registers empty

module pedal_adc_smoother_cc_core #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // sample transactions
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_op,
    input  logic [2:0]             i_channel,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [2:0]             i_controller_slot,

    // control-change transactions
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_out_midi_channel,
    output logic [6:0]             o_controller_number,
    output logic [6:0]             o_level,

    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    // configuration registers
    logic [7:0] r_channel_enable;
    logic [3:0] r_midi_channel;
    logic [6:0] r_controller_base;

    // input register
    logic                   r_in_valid;
    logic                   r_op;
    logic [2:0]             r_channel;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [2:0]             r_slot;

    // output register
    logic       r_out_valid;
    logic [3:0] r_out_midi_channel;
    logic [6:0] r_controller_number;
    logic [6:0] r_level;

    logic                   w_out_free;
    logic                   w_move;
    logic                   w_accept;
    logic                   w_active;
    logic                   n_in_valid;
    logic                   n_out_valid;
    pasc_pkg::t_store_ctl   w_ctl;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [SAMPLE_BITS-1:0] w_rep;
    logic [SAMPLE_BITS-1:0] w_filt_wdata;
    logic [6:0]             w_level;
    logic [6:0]             w_cc;

    // the output register frees up when empty or when its transaction is taken
    assign w_out_free = !r_out_valid || !i_out_stall;
    // the held sample is processed and retired when the result has somewhere to go
    assign w_move     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // channels beyond the store or masked off are dropped without touching state
    assign w_active = w_move
                   && (int'(r_channel) < NUM_CHANNELS)
                   && r_channel_enable[r_channel];

    pasc_state #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_channel    (r_channel),
        .i_ctl        (w_ctl),
        .i_filt_wdata (w_filt_wdata),
        .i_rep_wdata  (w_filt_wdata),
        .o_filt       (w_old),
        .o_rep        (w_rep)
    );

    pasc_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .i_active            (w_active),
        .i_op                (r_op),
        .i_sample            (r_sample),
        .i_slot              (r_slot),
        .i_base              (r_controller_base),
        .i_old               (w_old),
        .i_rep               (w_rep),
        .o_ctl               (w_ctl),
        .o_filt_wdata        (w_filt_wdata),
        .o_level             (w_level),
        .o_controller_number (w_cc)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_move) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_channel_enable  <= pasc_pkg::RST_CHANNEL_ENABLE;
            r_midi_channel    <= pasc_pkg::RST_MIDI_CHANNEL;
            r_controller_base <= pasc_pkg::RST_CONTROLLER_BASE;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pasc_pkg::CFG_CHANNEL_ENABLE: begin
                        r_channel_enable <= i_cfg_data;
                    end
                    pasc_pkg::CFG_MIDI_CHANNEL: begin
                        r_midi_channel <= i_cfg_data[3:0];
                    end
                    pasc_pkg::CFG_CONTROLLER_BASE: begin
                        r_controller_base <= i_cfg_data[6:0];
                    end
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_op;
            r_channel <= i_channel;
            r_sample  <= i_sample;
            r_slot    <= i_controller_slot;
        end
        if (w_ctl.emit) begin
            r_out_midi_channel  <= r_midi_channel;
            r_controller_number <= w_cc;
            r_level             <= w_level;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_midi_channel  = r_out_midi_channel;
    assign o_controller_number = r_controller_number;
    assign o_level             = r_level;

endmodule
